// ===== rtl/bale_pkg.sv =====
// Package for the bounded array list engine: list depth, field widths,
// request modes, sequencer states and the structs passed between modules.
// No dependencies.
package bale_pkg;

   localparam int LIST_DEPTH = 64;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = IDX_W + 1;
   localparam int DATA_W     = 32;

   typedef enum logic [2:0] {
      MODE_SEARCH        = 3'd0,
      MODE_APPEND        = 3'd1,
      MODE_POP           = 3'd2,
      MODE_DELETE_AT     = 3'd3,
      MODE_SEARCH_DELETE = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_RESP
   } state_type;

   // Port of the entry store.
   typedef struct packed {
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
   } mem_req_type;

   // Finished result offered by the sequencer.
   typedef struct packed {
      logic             valid;
      logic             ok;
      logic             found;
      logic [IDX_W-1:0] found_index;
      logic [CNT_W-1:0] count_after;
   } result_type;

endpackage

// ===== rtl/bale_store.sv =====
// Entry store of the list engine: one write port and one registered read port.
// Depends on bale_pkg.
module bale_store
   import bale_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] entry_mem_ff [LIST_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         entry_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= entry_mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bale_seq.sv =====
// Sequencer of the list engine: walks the store one entry per cycle for
// search and for the shift after a delete, and keeps the entry count.
// Depends on bale_pkg; drives bale_store through a mem_req_type port.
module bale_seq
   import bale_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [2:0]        req_mode,
   input  logic [DATA_W-1:0] req_value,
   input  logic [IDX_W-1:0]  req_position,
   output logic              idle,
   output mem_req_type       mem_req,
   input  logic [DATA_W-1:0] rd_data,
   output result_type        result,
   input  logic              result_taken
);

   state_type         state_ff, state_in;
   logic              sd_ff, sd_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              ok_ff, ok_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic accept;
   logic more;
   logic hit;
   logic pos_ok;

   assign accept = req_valid && (state_ff == ST_IDLE);
   // The walk pointer is compared against the count in both walking states.
   assign more   = rd_ptr_ff < count_ff;
   assign hit    = pend_ff && (rd_data == value_ff);
   assign pos_ok = {1'b0, req_position} < count_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_SEARCH || req_mode == MODE_SEARCH_DELETE) begin
                  state_in = ST_SCAN;
               end else if (req_mode == MODE_DELETE_AT && pos_ok) begin
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = sd_ff ? ST_SHIFT : ST_RESP;
            end else if (!pend_ff && !more) begin
               state_in = ST_RESP;
            end
         end
         ST_SHIFT: begin
            if (!pend_ff && !more) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (result_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and store control.
   always_comb begin
      sd_in      = sd_ff;
      value_in   = value_ff;
      count_in   = count_ff;
      rd_ptr_in  = rd_ptr_ff;
      pend_in    = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      ok_in      = ok_ff;
      found_in   = found_ff;
      idx_in     = idx_ff;
      mem_req    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ok_in     = 1'b0;
               found_in  = 1'b0;
               idx_in    = '0;
               rd_ptr_in = '0;
               value_in  = req_value;
               sd_in     = (req_mode == MODE_SEARCH_DELETE);
               unique case (req_mode)
                  MODE_APPEND: begin
                     if (count_ff < CNT_W'(LIST_DEPTH)) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = count_ff[IDX_W-1:0];
                        mem_req.wr_data = req_value;
                        count_in        = count_ff + CNT_W'(1);
                        ok_in           = 1'b1;
                     end
                  end
                  MODE_POP: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - CNT_W'(1);
                        ok_in    = 1'b1;
                     end
                  end
                  MODE_DELETE_AT: begin
                     rd_ptr_in = {1'b0, req_position} + CNT_W'(1);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               found_in  = 1'b1;
               idx_in    = cmp_idx_ff;
               ok_in     = !sd_ff;
               rd_ptr_in = {1'b0, cmp_idx_ff} + CNT_W'(1);
            end else if (more) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_ptr_ff[IDX_W-1:0];
               pend_in         = 1'b1;
               cmp_idx_in      = rd_ptr_ff[IDX_W-1:0];
               rd_ptr_in       = rd_ptr_ff + CNT_W'(1);
            end
         end
         ST_SHIFT: begin
            // Entry k+2 is read while entry k+1, read last cycle, lands at k.
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cmp_idx_ff;
               mem_req.wr_data = rd_data;
            end
            if (more) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = rd_ptr_ff[IDX_W-1:0];
               pend_in         = 1'b1;
               cmp_idx_in      = rd_ptr_ff[IDX_W-1:0] - IDX_W'(1);
               rd_ptr_in       = rd_ptr_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               count_in = count_ff - CNT_W'(1);
               ok_in    = 1'b1;
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      sd_ff      <= sd_in;
      value_ff   <= value_in;
      rd_ptr_ff  <= rd_ptr_in;
      cmp_idx_ff <= cmp_idx_in;
      ok_ff      <= ok_in;
      found_ff   <= found_in;
      idx_ff     <= idx_in;
   end

   assign idle               = (state_ff == ST_IDLE);
   assign result.valid       = (state_ff == ST_RESP);
   assign result.ok          = ok_ff;
   assign result.found       = found_ff;
   assign result.found_index = idx_ff;
   assign result.count_after = count_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LIST_DEPTH))
      else $error("entry count above list depth");

   // An append writes the slot just past the tail, so the address may equal the count.
   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> ({1'b0, mem_req.wr_addr} <= count_ff))
      else $error("store write outside the held entries");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_ff)
      else $error("read still pending while idle");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_APPEND && count_ff < CNT_W'(LIST_DEPTH))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not advance the count");

   a_shift_done_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && state_in == ST_RESP)
      |=> (count_ff == $past(count_ff) - CNT_W'(1) && ok_ff))
      else $error("delete did not drop the count");
`endif

endmodule

// ===== rtl/bounded_array_list_engine.sv =====
// Top level of the bounded array list engine: request handshake, sequencer,
// entry store and the response register. Depends on bale_pkg, bale_store, bale_seq.
//
//   channel   ports                                              direction
//   req       req_valid, req_stall, req_mode, req_value,
//             req_position                                       in
//   rsp       rsp_valid, rsp_stall, rsp_ok, rsp_found,
//             rsp_found_index, rsp_count_after                   out
//
// One request at a time; the store has one write port and one read port, read one
// entry per cycle with a registered result. After the request transfer, append,
// pop, unused modes and a failed delete go straight to the response; a search
// first scans the list, a delete at position p first shifts the entries above p,
// and a search and delete first scans and then shifts.
// Synchronous reset empties the list. req_stall is high while a request is in work.
// A stalled response stays in its register while the next request is already
// being worked on; a second result then waits in the sequencer.
module bounded_array_list_engine
   import bale_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_mode,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [IDX_W-1:0]         req_position,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_ok,
   output logic                     rsp_found,
   output logic [IDX_W-1:0]         rsp_found_index,
   output logic [CNT_W-1:0]         rsp_count_after
);

   mem_req_type       mem_req;
   logic [DATA_W-1:0] rd_data;
   result_type        result;
   logic              idle;
   logic              result_taken;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff;
   logic             rsp_found_ff;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   bale_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   bale_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .req_position (req_position),
      .idle         (idle),
      .mem_req      (mem_req),
      .rd_data      (rd_data),
      .result       (result),
      .result_taken (result_taken)
   );

   assign req_stall = !idle;

   // The result moves into the response register when it is empty or draining.
   assign result_taken = result.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = result_taken || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_taken) begin
         rsp_ok_ff    <= result.ok;
         rsp_found_ff <= result.found;
         rsp_idx_ff   <= result.found_index;
         rsp_count_ff <= result.count_after;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_idx_ff;
   assign rsp_count_after = rsp_count_ff;

endmodule

// ===== test/tb_bounded_array_list_engine.sv =====
// Self-checking testbench for bounded_array_list_engine: a scoreboard keeps its own copy
// of the list and predicts every response; tasks drive requests, a process drives stalls.
// Depends on bale_pkg and the engine RTL only.
module tb_bounded_array_list_engine;
   import bale_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] MODE_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] MODE_MID_UNUSED   = 3'd6;
   localparam logic [2:0] MODE_LAST_UNUSED  = 3'd7;
   localparam int         RANDOM_REQUESTS   = 1700;
   localparam int         DRAIN_CYCLES      = 100;

   localparam logic signed [DATA_W-1:0] VALUE_POOL [8] = '{
      32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd0,
      32'sd1, 32'sh5555_aaaa, -32'sd1000, 32'sh0000_0100
   };

   typedef enum int {PH_FILL, PH_CHURN, PH_DRAIN, PH_NOISE} phase_type;

   typedef struct packed {
      logic             ok;
      logic             found;
      logic [IDX_W-1:0] index;
      logic [CNT_W-1:0] count;
   } list_result_type;

   class list_scoreboard;
      logic signed [DATA_W-1:0] entries [LIST_DEPTH];
      int unsigned              count;
      list_result_type          expected_q [$];
      int                       errors;

      function new();
         count  = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit find_first(logic signed [DATA_W-1:0] v, output int where);
         where = 0;
         for (int k = 0; k < count; k++) begin
            if (entries[k] == v) begin
               where = k;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function bit remove_at(int unsigned pos);
         if (pos >= count) return 1'b0;
         for (int unsigned k = pos; k + 1 < count; k++) entries[k] = entries[k + 1];
         count--;
         return 1'b1;
      endfunction

      // Works out the response to one accepted request and updates the shadow list.
      function void note_request(logic [2:0] mode, logic signed [DATA_W-1:0] value,
                                 logic [IDX_W-1:0] position);
         list_result_type r;
         int              where;
         r     = '0;
         where = 0;
         case (mode)
            MODE_SEARCH: begin
               r.found = find_first(value, where);
               r.ok    = r.found;
            end
            MODE_APPEND: begin
               if (count < LIST_DEPTH) begin
                  entries[count] = value;
                  count++;
                  r.ok = 1'b1;
               end
            end
            MODE_POP: begin
               if (count > 0) begin
                  count--;
                  r.ok = 1'b1;
               end
            end
            MODE_DELETE_AT: r.ok = remove_at(position);
            MODE_SEARCH_DELETE: begin
               r.found = find_first(value, where);
               if (r.found) r.ok = remove_at(where);
            end
            default: ;
         endcase
         // The index is taken before the entry is removed.
         if (r.found) r.index = where[IDX_W-1:0];
         r.count = count[CNT_W-1:0];
         expected_q.push_back(r);
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endtask

      task check_result(logic ok, logic found, logic [IDX_W-1:0] index,
                        logic [CNT_W-1:0] cnt);
         list_result_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("response with none pending (ok %b found %b idx %0d cnt %0d)",
                             ok, found, index, cnt));
         end else begin
            e = expected_q.pop_front();
            if (ok !== e.ok)
               report($sformatf("ok %b, predicted %b", ok, e.ok));
            if (found !== e.found)
               report($sformatf("found %b, predicted %b", found, e.found));
            if (index !== e.index)
               report($sformatf("found_index %0d, predicted %0d", index, e.index));
            if (cnt !== e.count)
               report($sformatf("count_after %0d, predicted %0d", cnt, e.count));
         end
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [2:0]               req_mode;
   logic signed [DATA_W-1:0] req_value;
   logic [IDX_W-1:0]         req_position;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_ok;
   logic                     rsp_found;
   logic [IDX_W-1:0]         rsp_found_index;
   logic [CNT_W-1:0]         rsp_count_after;

   list_scoreboard sb = new();
   int             burst_left = 0;
   int             sent = 0;

   bounded_array_list_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ok          (rsp_ok),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index),
      .rsp_count_after (rsp_count_after)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_ok, rsp_found, rsp_found_index, rsp_count_after);
   end

   // Offers one request, holds it until the transfer, then either keeps valid up for the
   // next request of the burst or drops it for a random gap.
   task automatic send_request(logic [2:0] mode, logic signed [DATA_W-1:0] value,
                               logic [IDX_W-1:0] position);
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_value    <= value;
      req_position <= position;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(mode, value, position);
      sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 10);
      end
   endtask

   // Called right after send_request, so valid is lowered before the next edge.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value(int present_pct);
      if (sb.count > 0 && $urandom_range(0, 99) < present_pct)
         return sb.entries[$urandom_range(0, sb.count - 1)];
      if ($urandom_range(0, 99) < 60)
         return VALUE_POOL[$urandom_range(0, 7)];
      return $urandom();
   endfunction

   function automatic logic [IDX_W-1:0] pick_position(phase_type phase);
      if (phase != PH_NOISE && sb.count > 0 && $urandom_range(0, 99) < 75)
         return IDX_W'($urandom_range(0, sb.count - 1));
      return IDX_W'($urandom_range(0, LIST_DEPTH - 1));
   endfunction

   function automatic logic [2:0] pick_mode(phase_type phase);
      int r;
      r = $urandom_range(0, 99);
      case (phase)
         PH_FILL: begin
            if (r < 70) return MODE_APPEND;
            if (r < 82) return MODE_SEARCH;
            if (r < 88) return MODE_SEARCH_DELETE;
            if (r < 93) return MODE_DELETE_AT;
            if (r < 97) return MODE_POP;
         end
         PH_CHURN: begin
            if (r < 30) return MODE_APPEND;
            if (r < 50) return MODE_SEARCH;
            if (r < 70) return MODE_SEARCH_DELETE;
            if (r < 85) return MODE_DELETE_AT;
            if (r < 95) return MODE_POP;
         end
         PH_DRAIN: begin
            if (r < 10) return MODE_APPEND;
            if (r < 25) return MODE_SEARCH;
            if (r < 50) return MODE_SEARCH_DELETE;
            if (r < 75) return MODE_DELETE_AT;
            if (r < 98) return MODE_POP;
         end
         default: begin
            if (r < 15) return MODE_APPEND;
            if (r < 35) return MODE_SEARCH;
            if (r < 45) return MODE_POP;
            if (r < 70) return MODE_DELETE_AT;
         end
      endcase
      return 3'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
   endfunction

   // Receiver: random stall patterns, stretches without stalls, and long hold-offs that
   // back the engine up until it stalls its request side.
   initial begin
      int duty;
      rsp_stall <= 1'b0;
      for (int seg = 0; ; seg++) begin
         if (seg == 6 || $urandom_range(0, 24) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(150, 400)) @(posedge clock);
         end else begin
            duty = 15 * $urandom_range(0, 4);
            repeat ($urandom_range(20, 200)) begin
               rsp_stall <= ($urandom_range(0, 99) < duty);
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      #100_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      phase_type  phase;
      int         phase_len;
      int         mode_pct;
      logic [2:0] mode;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_mode     <= MODE_SEARCH;
      req_value    <= '0;
      req_position <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty list, unused modes, extreme values, duplicates,
      // positions at and beyond the count, and misses.
      send_request(MODE_SEARCH,        32'sd0,          '0);
      send_request(MODE_POP,           32'sd0,          '0);
      send_request(MODE_DELETE_AT,     32'sd0,          '0);
      send_request(MODE_SEARCH_DELETE, 32'sh7fff_ffff,  '0);
      send_request(MODE_FIRST_UNUSED,  -32'sd1,         '1);
      send_request(MODE_MID_UNUSED,    -32'sd1,         '1);
      send_request(MODE_LAST_UNUSED,   -32'sd1,         '1);
      send_request(MODE_APPEND,        32'sh8000_0000,  '0);
      send_request(MODE_APPEND,        32'sh7fff_ffff,  '1);
      send_request(MODE_APPEND,        -32'sd1,         '0);
      send_request(MODE_APPEND,        32'sd0,          '0);
      send_request(MODE_APPEND,        32'sh7fff_ffff,  '0);
      send_request(MODE_SEARCH,        32'sh7fff_ffff,  '0);
      send_request(MODE_SEARCH,        32'sd12345,      '0);
      send_request(MODE_DELETE_AT,     32'sd0,          '1);
      send_request(MODE_DELETE_AT,     32'sd0,          IDX_W'(5));
      send_request(MODE_SEARCH_DELETE, 32'sh7fff_ffff,  '0);
      send_request(MODE_SEARCH,        32'sh7fff_ffff,  '0);
      send_request(MODE_DELETE_AT,     32'sd0,          IDX_W'(3));
      send_request(MODE_DELETE_AT,     32'sd0,          '0);
      send_request(MODE_SEARCH_DELETE, 32'sh1234_5678,  '0);
      send_request(MODE_POP,           32'sd0,          '0);
      send_request(MODE_LAST_UNUSED,   32'sh8000_0000,  '0);
      send_request(MODE_POP,           32'sd0,          '0);
      wait_until_drained();

      // Random part in phases; the first one is long enough to fill the list.
      sent = 0;
      phase     = PH_FILL;
      phase_len = 200;
      while (sent < RANDOM_REQUESTS) begin
         repeat (phase_len) begin
            mode     = pick_mode(phase);
            mode_pct = (phase == PH_NOISE) ? 10 : 65;
            send_request(mode, pick_value(mode == MODE_APPEND ? 10 : mode_pct),
                         pick_position(phase));
         end
         if ($urandom_range(0, 3) == 0) wait_until_drained();
         phase     = phase_type'($urandom_range(0, 3));
         phase_len = $urandom_range(20, 120);
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bale_pkg.sv
rtl/bale_store.sv
rtl/bale_seq.sv
rtl/bounded_array_list_engine.sv
test/tb_bounded_array_list_engine.sv
